// ===== hdl/hec_pkg.sv =====
// ----------------------------------------------------------------------------
// hec_pkg
// Types, constants and constant functions shared by the Hamming coder files.
// ----------------------------------------------------------------------------
package hec_pkg;

  localparam int CODE_W  = 63;  // codeword bits, bit k-1 holds position k
  localparam int POS_W   = 6;   // width of a position / syndrome
  localparam int CFG_W   = 6;   // width of the data length register
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 72;

  localparam logic ACTION_ENCODE = 1'b0;
  localparam logic ACTION_CHECK  = 1'b1;

  localparam logic [CFG_W-1:0] DATA_BITS_RESET = 6'd57;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef struct packed {
    logic uncorrectable;
    logic error_found;
    pos_t error_position;
    code_t code_word;
  } result_t;

  // Least r with 2^r >= m + r + 1.
  function automatic int parity_cnt(int m);
    int r;
    r = 0;
    for (int i = 0; i < 8; i++) begin
      if ((1 << r) < m + r + 1) begin
        r = r + 1;
      end
    end
    return r;
  endfunction

  // Largest data length whose codeword fits in lim bits.
  function automatic int max_data(int lim);
    int best;
    best = 1;
    for (int m = 1; m <= 63; m++) begin
      if (m + parity_cnt(m) <= lim) begin
        best = m;
      end
    end
    return best;
  endfunction

  // Positions whose index has bit i set.
  function automatic code_t col_mask(int i);
    code_t msk;
    for (int k = 1; k <= CODE_W; k++) begin
      msk[k-1] = k[i];
    end
    return msk;
  endfunction

  // Data bit index carried at non-power-of-two position k.
  function automatic int data_index(int k);
    int p;
    p = 0;
    for (int i = 0; i < POS_W; i++) begin
      if ((1 << i) <= k) begin
        p = p + 1;
      end
    end
    return k - 1 - p;
  endfunction

  function automatic pos_t syndrome(code_t cw);
    pos_t s;
    for (int i = 0; i < POS_W; i++) begin
      s[i] = ^(cw & col_mask(i));
    end
    return s;
  endfunction

endpackage

// ===== hdl/hec_cfg.sv =====
// ----------------------------------------------------------------------------
// hec_cfg
// Data length register; keeps the clamped codeword length and its bit mask.
// ----------------------------------------------------------------------------
module hec_cfg import hec_pkg::*; #(
  parameter int MAX_CODE_BITS = 63
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data,
  output pos_t             code_len,
  output code_t            code_mask
);

  localparam int CODE_LIM = (MAX_CODE_BITS > 63) ? 63 : MAX_CODE_BITS;
  localparam int M_MAX    = max_data(CODE_LIM);
  localparam int N_RESET  = ((int'(DATA_BITS_RESET) > M_MAX) ? M_MAX : int'(DATA_BITS_RESET))
                            + parity_cnt((int'(DATA_BITS_RESET) > M_MAX) ? M_MAX
                                         : int'(DATA_BITS_RESET));

  logic [CFG_W-1:0] m_eff;
  pos_t  n_r, n_nxt;
  code_t mask_r, mask_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    m_eff = cfg_data;
    if (m_eff == '0) begin
      m_eff = CFG_W'(1);
    end
    if (int'(m_eff) > M_MAX) begin
      m_eff = CFG_W'(M_MAX);
    end
    n_nxt    = POS_W'(int'(m_eff) + parity_cnt(int'(m_eff)));
    mask_nxt = {CODE_W{1'b1}} >> (CODE_W'(CODE_W) - CODE_W'(n_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r    <= POS_W'(N_RESET);
      mask_r <= {CODE_W{1'b1}} >> (CODE_W - N_RESET);
    end else if (cfg_valid) begin
      n_r    <= n_nxt;
      mask_r <= mask_nxt;
    end
  end

  assign code_len  = n_r;
  assign code_mask = mask_r;

endmodule

// ===== hdl/hec_xcode.sv =====
// ----------------------------------------------------------------------------
// hec_xcode
// Encode or check/correct one word: bit spreading, parity XOR trees, flip.
// ----------------------------------------------------------------------------
module hec_xcode import hec_pkg::*; (
  input  logic    action,
  input  code_t   word,
  input  pos_t    code_len,
  input  code_t   code_mask,
  output result_t result
);

  code_t spread;
  code_t enc_cw;
  code_t chk_cw;
  pos_t  enc_s;
  pos_t  chk_s;
  code_t flip;

  // Data bits land on every position that is not a power of two; bits that
  // fall beyond n are cleared by the mask.
  always_comb begin
    spread = '0;
    for (int k = 1; k <= CODE_W; k++) begin
      if ((k & (k - 1)) != 0) begin
        spread[k-1] = word[data_index(k)];
      end
    end
  end

  always_comb begin
    enc_cw = spread & code_mask;
    enc_s  = syndrome(enc_cw);
    for (int i = 0; i < POS_W; i++) begin
      enc_cw[(1 << i) - 1] = enc_s[i];
    end
    enc_cw = enc_cw & code_mask;

    chk_cw = word & code_mask;
    chk_s  = syndrome(chk_cw);
    flip   = '0;
    if (chk_s != '0 && chk_s <= code_len) begin
      flip = code_t'(1) << (chk_s - POS_W'(1));
    end
  end

  always_comb begin
    unique case (action)
      ACTION_ENCODE: begin
        result.code_word      = enc_cw;
        result.error_position = '0;
        result.error_found    = 1'b0;
        result.uncorrectable  = 1'b0;
      end
      ACTION_CHECK: begin
        result.code_word      = chk_cw ^ flip;
        result.error_position = chk_s;
        result.error_found    = (chk_s != '0);
        result.uncorrectable  = (chk_s > code_len);
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

// ===== hdl/hamming_encode_correct_unit.sv =====
// ----------------------------------------------------------------------------
// hamming_encode_correct_unit
// Even-parity Hamming single-error-correcting encoder and checker.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_*  : write the data length m (1..57 by default); takes effect on the
//            next request. Write only while no request is in flight.
//   in_*   : one request per handshake. in_tuser selects encode (0) or
//            check/correct (1); in_tdata carries the data word or codeword.
//   out_*  : one result per request, in order: codeword, syndrome, error
//            found and uncorrectable flags.
// A request passes one input register, the XOR trees and one result register
// before out_tvalid. Throughput is one request per cycle while out_tready is
// high; both registers advance together when the result is taken.
// When out_tready is low the result holds, the input register still fills
// once, and in_tready then drops until the result is taken.
// Reset clears both valid flags and sets m to 57.
// ----------------------------------------------------------------------------
module hamming_encode_correct_unit import hec_pkg::*; #(
  parameter int MAX_CODE_BITS = 63
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,       // data_bits
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,       // word[62:0], pad
  input  logic                   in_tuser,       // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata       // code_word, error_position,
                                                 // error_found, uncorrectable, pad
);

  pos_t    code_len;
  code_t   code_mask;
  result_t result;

  logic    s1_valid_r;
  logic    s1_action_r;
  code_t   s1_word_r;
  logic    out_valid_r;
  result_t out_res_r;
  logic    out_adv;

  hec_cfg #(
    .MAX_CODE_BITS(MAX_CODE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .code_len (code_len),
    .code_mask(code_mask)
  );

  hec_xcode u_xcode (
    .action   (s1_action_r),
    .word     (s1_word_r),
    .code_len (code_len),
    .code_mask(code_mask),
    .result   (result)
  );

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r <= in_tuser;
      s1_word_r   <= in_tdata[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r.uncorrectable, out_res_r.error_found,
                       out_res_r.error_position, out_res_r.code_word};

endmodule

// ===== dv/tb_hamming_encode_correct_unit.sv =====
// ----------------------------------------------------------------------------
// tb_hamming_encode_correct_unit
// Self-checking bench for the Hamming SEC encoder/checker. Every accepted
// request is predicted into a queue. Each result taken from the output
// stream is compared field by field with the oldest prediction. Directed
// requests come first: the default and short data lengths, out-of-range
// lengths, ignored input bits and syndromes past the codeword end. Random
// traffic follows across many data lengths, with random gaps on both sides
// and one stretch with no gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hamming_encode_correct_unit import hec_pkg::*;;

  localparam int MAX_DATA_LEN = 57;      // largest m with m + r <= 63
  localparam int CYCLE_LIMIT  = 400000;
  localparam int ITEMS_PER_LEN = 120;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // word[62:0], pad
  logic                   in_tuser   = 1'b0;  // action
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // code_word, error_position, error_found,
                                      // uncorrectable, pad

  logic [CFG_W-1:0] data_bits_q = DATA_BITS_RESET;
  result_t          pending_codewords[$];
  result_t          got_res;
  result_t          want_res;
  int               mismatches = 0;
  int               cycles = 0;
  bit               no_gaps = 1'b0;

  hamming_encode_correct_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int data_len(logic [CFG_W-1:0] dbits);
    int m;
    m = int'(dbits);
    if (m < 1) begin
      m = 1;
    end
    if (m > MAX_DATA_LEN) begin
      m = MAX_DATA_LEN;
    end
    return m;
  endfunction

  function automatic int parity_len(int m);
    int r;
    r = 0;
    while ((1 << r) < m + r + 1) begin
      r++;
    end
    return r;
  endfunction

  // XOR of the indices of all set positions 1..n
  function automatic pos_t position_xor(code_t cw, int n);
    pos_t s;
    s = '0;
    for (int k = 1; k <= n; k++) begin
      if (cw[k-1]) begin
        s = s ^ pos_t'(k);
      end
    end
    return s;
  endfunction

  function automatic result_t code_or_correct(logic act, code_t word,
                                              logic [CFG_W-1:0] dbits);
    result_t    res;
    int         m;
    int         r;
    int         n;
    int         d;
    logic [63:0] mask;
    code_t      cw;
    pos_t       s;
    m    = data_len(dbits);
    r    = parity_len(m);
    n    = m + r;
    mask = (64'd1 << n) - 64'd1;
    res  = '0;
    cw   = '0;
    if (act == ACTION_ENCODE) begin
      d = 0;
      for (int k = 1; k <= n; k++) begin
        if ((k & (k - 1)) != 0) begin
          cw[k-1] = word[d];
          d++;
        end
      end
      s = position_xor(cw, n);
      for (int i = 0; i < r; i++) begin
        if (s[i]) begin
          cw[(1 << i) - 1] = 1'b1;
        end
      end
    end else begin
      cw = word & mask[CODE_W-1:0];
      s  = position_xor(cw, n);
      res.error_position = s;
      res.error_found    = (s != 0);
      if (s != 0) begin
        if (int'(s) <= n) begin
          cw[s-1] = ~cw[s-1];
        end else begin
          res.uncorrectable = 1'b1;
        end
      end
    end
    res.code_word = cw & mask[CODE_W-1:0];
    return res;
  endfunction

  function automatic code_t encoded(code_t data);
    result_t res;
    res = code_or_correct(ACTION_ENCODE, data, data_bits_q);
    return res.code_word;
  endfunction

  function automatic code_t rand_word();
    return code_t'({$urandom, $urandom});
  endfunction

  // ----------------------------------------------------------- monitors

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_codewords.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      pending_codewords.push_back(code_or_correct(in_tuser, in_tdata[CODE_W-1:0],
                                                  data_bits_q));
    end
  end

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches < 40) begin
      $display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata[$bits(result_t)-1:0]);
      if (pending_codewords.size() == 0) begin
        flag_mismatch("unrequested result", 64'(got_res.code_word), 64'd0);
      end else begin
        want_res = pending_codewords.pop_front();
        if (got_res.code_word !== want_res.code_word)
          flag_mismatch("code_word", 64'(got_res.code_word), 64'(want_res.code_word));
        if (got_res.error_position !== want_res.error_position)
          flag_mismatch("error_position", 64'(got_res.error_position),
                        64'(want_res.error_position));
        if (got_res.error_found !== want_res.error_found)
          flag_mismatch("error_found", 64'(got_res.error_found),
                        64'(want_res.error_found));
        if (got_res.uncorrectable !== want_res.uncorrectable)
          flag_mismatch("uncorrectable", 64'(got_res.uncorrectable),
                        64'(want_res.uncorrectable));
      end
    end
  end

  // result side backpressure
  always @(negedge clk) begin
    out_tready = no_gaps || ($urandom_range(0, 99) >= 32);
  end

  // ----------------------------------------------------------- drivers
  // All driving tasks are entered and left at a falling edge.

  task automatic send_item(logic act, code_t word);
    if (!no_gaps && $urandom_range(0, 99) < 32) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = act;
    in_tdata  = {1'b0, word};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_codewords.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // only called with the unit idle
  task automatic write_data_bits(logic [CFG_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    data_bits_q = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ----------------------------------------------------------- tests

  task automatic test_default_length();
    code_t ones;
    ones = '1;
    send_item(ACTION_ENCODE, '0);
    send_item(ACTION_ENCODE, ones);
    send_item(ACTION_ENCODE, code_t'({32{2'b01}}));
    send_item(ACTION_ENCODE, code_t'(1));
    send_item(ACTION_CHECK, '0);
    send_item(ACTION_CHECK, ones);
    // single errors at the first, last and a parity position
    send_item(ACTION_CHECK, encoded(ones) ^ code_t'(1));
    send_item(ACTION_CHECK, encoded(ones) ^ (code_t'(1) << 62));
    send_item(ACTION_CHECK, encoded(code_t'({32{2'b01}})) ^ (code_t'(1) << 31));
    // double error gives a wrong correction
    send_item(ACTION_CHECK, encoded(ones) ^ code_t'(63'h204));
    wait_drained();
  endtask

  task automatic test_short_lengths();
    code_t ones;
    ones = '1;
    // m = 5: n = 9, syndromes 10..15 point past the end
    write_data_bits(6'd5);
    send_item(ACTION_ENCODE, code_t'(5'h1f));
    send_item(ACTION_CHECK, code_t'(63'h82));
    send_item(ACTION_CHECK, encoded(code_t'(5'h15)) | (ones << 9));
    send_item(ACTION_CHECK, encoded(code_t'(5'h0a)) ^ (code_t'(1) << 8));
    wait_drained();
    // zero length behaves as one data bit
    write_data_bits(6'd0);
    send_item(ACTION_ENCODE, code_t'(1));
    send_item(ACTION_ENCODE, code_t'(2));
    send_item(ACTION_CHECK, code_t'(3'b111));
    send_item(ACTION_CHECK, code_t'(3'b100));
    wait_drained();
    // lengths above the largest fitting one clamp to it
    write_data_bits(6'd63);
    send_item(ACTION_ENCODE, ones);
    send_item(ACTION_CHECK, encoded(ones) ^ (code_t'(1) << 40));
    wait_drained();
    write_data_bits(6'd58);
    send_item(ACTION_ENCODE, rand_word());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] lens[12];
    int    roll;
    int    n;
    code_t cw;
    lens = '{6'd1, 6'd2, 6'd3, 6'd4, 6'd57, 6'd63, 6'd0, 6'd11, 6'd26, 6'd31,
             6'd0, 6'd0};
    lens[10] = CFG_W'($urandom_range(0, 63));
    lens[11] = CFG_W'($urandom_range(0, 63));
    foreach (lens[c]) begin
      write_data_bits(lens[c]);
      n = data_len(data_bits_q) + parity_len(data_len(data_bits_q));
      for (int j = 0; j < ITEMS_PER_LEN; j++) begin
        // hold off the sender until everything requested has come back
        if (c == 3 && j == ITEMS_PER_LEN / 2) begin
          wait_drained();
        end
        roll = $urandom_range(0, 99);
        if (roll < 30) begin
          send_item(ACTION_ENCODE, rand_word());
        end else if (roll < 85) begin
          // valid codeword with zero, one or two flipped positions
          cw = encoded(rand_word());
          repeat ($urandom_range(0, 2)) begin
            cw[$urandom_range(1, n) - 1] ^= 1'b1;
          end
          send_item(ACTION_CHECK, cw);
        end else begin
          send_item(ACTION_CHECK, rand_word());
        end
      end
      wait_drained();
    end
  endtask

  task automatic test_back_to_back();
    write_data_bits(CFG_W'($urandom_range(1, 57)));
    no_gaps = 1'b1;
    for (int j = 0; j < 200; j++) begin
      if ($urandom_range(0, 1) == 0) begin
        send_item(ACTION_ENCODE, rand_word());
      end else begin
        send_item(ACTION_CHECK,
                  ($urandom_range(0, 3) == 0) ? rand_word()
                  : encoded(rand_word()) ^ (code_t'(1) << $urandom_range(0, 62)));
      end
    end
    wait_drained();
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_default_length();
    test_short_lengths();
    test_random_traffic();
    test_back_to_back();
    if (mismatches == 0 && pending_codewords.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
